>>> hw/rtl/des_rnd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package des_rnd_pkg;

    localparam int HALF_W = 32;
    localparam int KEY_W  = 48;

    // Expansion table: output bit n (n = 1 is the MSB) takes bit E_SEL[n-1] of R.
    localparam logic [5:0] E_SEL [KEY_W] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_SEL [HALF_W] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [3:0] SBOX [8][4][16] = '{
        '{'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
            4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
          '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
            4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
          '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
            4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
          '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
            4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13}},
        '{'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
            4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
          '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
            4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
          '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
            4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
          '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
            4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9}},
        '{'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
            4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
          '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
            4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
          '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
            4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
          '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
            4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12}},
        '{'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
            4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
          '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
            4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
          '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
            4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
          '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
            4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14}},
        '{'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
            4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
          '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
            4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
          '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
            4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
          '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
            4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3}},
        '{'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
            4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
          '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
            4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
          '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
            4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
          '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
            4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13}},
        '{'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
            4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
          '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
            4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
          '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
            4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
          '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
            4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12}},
        '{'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
            4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
          '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
            4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
          '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
            4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
          '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
            4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}}
    };

    // Round function f(R, K): expansion, key mix, S-boxes and P permutation.
    // Bit n in DES numbering (1 is the MSB) of a 32-bit word sits at index 32 - n.
    function automatic logic [HALF_W-1:0] des_f(input logic [HALF_W-1:0] r,
                                                 input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0]  m;
        logic [HALF_W-1:0] z;
        logic [HALF_W-1:0] p;
        logic [5:0]        six;
        logic [1:0]        row;
        logic [3:0]        col;
        for (int i = 0; i < KEY_W; i++)
        begin
            m[KEY_W-1-i] = r[5'(HALF_W - int'(E_SEL[i]))];
        end
        m = m ^ k;
        for (int i = 0; i < 8; i++)
        begin
            six = m[KEY_W-1-6*i -: 6];
            row = {six[5], six[0]};
            col = six[4:1];
            z[HALF_W-1-4*i -: 4] = SBOX[i][row][col];
        end
        for (int i = 0; i < HALF_W; i++)
        begin
            p[HALF_W-1-i] = z[5'(HALF_W - int'(P_SEL[i]))];
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/des_rnd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface des_rnd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_half;
    logic [31:0] right_half;
    logic [47:0] round_key;
    logic        final_round;

    modport source (output valid, output left_half, output right_half,
                    output round_key, output final_round, input ready);
    modport sink (input valid, input left_half, input right_half,
                  input round_key, input final_round, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/des_rnd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface des_rnd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_result;
    logic [31:0] right_result;

    modport source (output valid, output left_result, output right_result, input ready);
    modport sink (input valid, input left_result, input right_result, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/des_feistel_round.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction   Payload
// item      in          left_half, right_half, round_key, final_round
// result    out         left_result, right_result
//
// One request is taken per cycle while item.ready is high. Each request passes
// through the input register and then the result register, which bracket
// the round function (expansion, S-box lookups, P permutation and XOR).
// Reset clears only the two valid flags. A stalled result holds in its register,
// and the input register keeps taking requests as long as it can hand on its own.

module des_feistel_round (
    input  wire logic      clk,
    input  wire logic      rst_n,
    des_rnd_in_if.sink     item,
    des_rnd_out_if.source  result
);

    logic                              in_valid_reg;
    logic [des_rnd_pkg::HALF_W-1:0]    in_left_reg;
    logic [des_rnd_pkg::HALF_W-1:0]    in_right_reg;
    logic [des_rnd_pkg::KEY_W-1:0]     in_key_reg;
    logic                              in_final_reg;

    logic                              out_valid_reg;
    logic [des_rnd_pkg::HALF_W-1:0]    out_left_reg;
    logic [des_rnd_pkg::HALF_W-1:0]    out_right_reg;

    logic                              out_load;
    logic                              in_load;
    logic [des_rnd_pkg::HALF_W-1:0]    mixed;

    // The result register takes a new value when it is empty or being drained.
    assign out_load   = !out_valid_reg || result.ready;
    assign item.ready = !in_valid_reg || out_load;
    assign in_load    = item.valid && item.ready;

    assign mixed = in_left_reg ^ des_rnd_pkg::des_f(in_right_reg, in_key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_left_reg  <= item.left_half;
            in_right_reg <= item.right_half;
            in_key_reg   <= item.round_key;
            in_final_reg <= item.final_round;
        end
        if (out_load && in_valid_reg)
        begin
            // The last round leaves the halves unswapped.
            if (in_final_reg)
            begin
                out_left_reg  <= mixed;
                out_right_reg <= in_right_reg;
            end
            else
            begin
                out_left_reg  <= in_right_reg;
                out_right_reg <= mixed;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.left_result  = out_left_reg;
    assign result.right_result = out_right_reg;

endmodule

`default_nettype wire
